[src/rspe_pkg.sv]
// ----------------------------------------------------------------------------
// rspe_pkg
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity
// encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

	localparam int MAX_EC_WORDS_DEF = 32;
	localparam int QUEUE_DEPTH      = 2;
	localparam int EC_W             = 6;

	localparam logic [EC_W-1:0] EC_WORDS_RST = 6'd10;
	// Low byte of the field polynomial x^8+x^4+x^3+x^2+1.
	localparam logic [7:0]      GF_POLY_LOW  = 8'h1D;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_BUILD,
		ST_RUN
	} gen_state_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] gf_xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? GF_POLY_LOW : 8'h00);
	endfunction

	function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = '0;
		x   = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				acc = acc ^ x;
			end
			x = gf_xtime(x);
		end
		return acc;
	endfunction

endpackage

`default_nettype wire

[src/rspe_front.sv]
// ----------------------------------------------------------------------------
// rspe_front
// Generator builder and parity LFSR. Takes one data byte per cycle while full
// is low, handing the finished parity block to the queue on the last byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_front import rspe_pkg::*; #(
	parameter int MAX_EC_WORDS = MAX_EC_WORDS_DEF,
	parameter int NW           = $clog2(MAX_EC_WORDS + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [EC_W-1:0]  cfg_wdata,
	input  wire logic             push,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output logic                  full,
	input  wire q_status_t        q_stat,
	output logic                  enq,
	output logic [7:0]            enq_blk [MAX_EC_WORDS],
	output logic [NW-1:0]         n_eff
);

	localparam int CW = (NW > EC_W) ? NW + 1 : EC_W + 1;
	localparam int IW = $clog2(MAX_EC_WORDS);

	gen_state_t        state_q, state_nx;
	logic              do_init, do_build, running;
	logic [EC_W-1:0]   ec_q;
	logic [CW-1:0]     ec_ext;
	logic [7:0]        g_q    [MAX_EC_WORDS];
	logic [7:0]        p_q    [MAX_EC_WORDS];
	logic [7:0]        prod   [MAX_EC_WORDS];
	logic [7:0]        p_next [MAX_EC_WORDS];
	logic [7:0]        g_next [MAX_EC_WORDS];
	logic [7:0]        root_q;
	logic [NW-1:0]     iter_q;
	logic [IW-1:0]     top_idx;
	logic [7:0]        fb;
	logic [7:0]        mul_b;
	logic              accept;

	// The parity count saturates into the supported range.
	always_comb begin
		ec_ext = CW'(ec_q);
		if (ec_ext < CW'(2)) begin
			n_eff = NW'(2);
		end else if (ec_ext > CW'(MAX_EC_WORDS)) begin
			n_eff = NW'(MAX_EC_WORDS);
		end else begin
			n_eff = NW'(ec_ext);
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_INIT:  state_nx = ST_BUILD;
			ST_BUILD: begin
				if (iter_q == n_eff - NW'(1)) begin
					state_nx = ST_RUN;
				end
			end
			ST_RUN:   state_nx = ST_RUN;
			default:  state_nx = ST_INIT;
		endcase
		if (cfg_we) begin
			state_nx = ST_INIT;
		end
	end

	always_comb begin
		do_init  = 1'b0;
		do_build = 1'b0;
		running  = 1'b0;
		case (state_q)
			ST_INIT:  do_init  = 1'b1;
			ST_BUILD: do_build = 1'b1;
			ST_RUN:   running  = 1'b1;
			default:  do_init  = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ec_q    <= EC_WORDS_RST;
		end else begin
			state_q <= state_nx;
			if (cfg_we) begin
				ec_q <= cfg_wdata;
			end
		end
	end

	assign full   = !running || q_stat.full;
	assign accept = push && !full;
	assign enq    = accept && last_byte;

	// The multiplier row is shared: it scales by the current root while the
	// generator is built and by the feedback byte while data flows.
	assign top_idx = IW'(n_eff - NW'(1));
	assign fb      = p_q[top_idx] ^ data_byte;
	assign mul_b   = do_build ? root_q : fb;

	always_comb begin
		for (int i = 0; i < MAX_EC_WORDS; i++) begin
			prod[i] = gf_mul(g_q[i], mul_b);
		end
		p_next[0] = prod[0];
		g_next[0] = prod[0];
		for (int i = 1; i < MAX_EC_WORDS; i++) begin
			if (NW'(i) < n_eff) begin
				p_next[i] = p_q[i-1] ^ prod[i];
				g_next[i] = g_q[i-1] ^ prod[i];
			end else begin
				p_next[i] = '0;
				g_next[i] = g_q[i];
			end
		end
	end

	assign enq_blk = p_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
		end else if (do_init) begin
			iter_q <= '0;
		end else if (do_build) begin
			iter_q <= iter_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_init) begin
			root_q <= 8'h01;
			for (int i = 0; i < MAX_EC_WORDS; i++) begin
				g_q[i] <= (i == 0) ? 8'h01 : 8'h00;
				p_q[i] <= '0;
			end
		end else if (do_build) begin
			root_q <= gf_xtime(root_q);
			g_q    <= g_next;
		end else if (accept) begin
			for (int i = 0; i < MAX_EC_WORDS; i++) begin
				p_q[i] <= last_byte ? 8'h00 : p_next[i];
			end
		end
	end

endmodule

`default_nettype wire

[src/rspe_queue.sv]
// ----------------------------------------------------------------------------
// rspe_queue
// Short queue of finished parity blocks between the LFSR and the output
// sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_queue import rspe_pkg::*; #(
	parameter int MAX_EC_WORDS = MAX_EC_WORDS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       enq,
	input  wire logic [7:0] enq_blk [MAX_EC_WORDS],
	input  wire logic       deq,
	output logic [7:0]      head_blk [MAX_EC_WORDS],
	output q_status_t       q_stat
);

	localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

	logic [7:0]      mem_q [QUEUE_DEPTH][MAX_EC_WORDS];
	logic [QW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0] cnt_q;
	logic            do_wr, do_rd;

	assign q_stat.full  = (cnt_q == CNTW'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);
	assign do_wr = enq && !q_stat.full;
	assign do_rd = deq && !q_stat.empty;
	assign head_blk = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QW'(1);
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + CNTW'(1);
				2'b01:   cnt_q <= cnt_q - CNTW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= enq_blk;
		end
	end

endmodule

`default_nettype wire

[src/rspe_back.sv]
// ----------------------------------------------------------------------------
// rspe_back
// Output sequencer. Walks the head parity block from the highest register
// down and retires the block after its final byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_back import rspe_pkg::*; #(
	parameter int MAX_EC_WORDS = MAX_EC_WORDS_DEF,
	parameter int NW           = $clog2(MAX_EC_WORDS + 1)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [7:0]    head_blk [MAX_EC_WORDS],
	input  wire q_status_t     q_stat,
	input  wire logic [NW-1:0] n_eff,
	input  wire logic          pop,
	output logic               deq,
	output logic               empty,
	output logic [7:0]         parity_byte,
	output logic               parity_last
);

	localparam int IW = $clog2(MAX_EC_WORDS);

	logic [IW-1:0] pos_q;
	logic [NW-1:0] rem;
	logic          take;

	assign empty       = q_stat.empty;
	assign rem         = n_eff - NW'(1) - NW'(pos_q);
	assign parity_byte = head_blk[rem[IW-1:0]];
	assign parity_last = (rem == '0);
	assign take        = pop && !empty;
	assign deq         = take && parity_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			pos_q <= parity_last ? '0 : pos_q + IW'(1);
		end
	end

endmodule

`default_nettype wire

[src/reed_solomon_parity_encoder.sv]
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic Reed-Solomon parity encoder over GF(256), polynomial 0x11D.
// ----------------------------------------------------------------------------
// Input side: a byte is taken when push is high and full is low. last_byte
// marks the final data byte of a message. One byte per cycle is accepted
// while the block queue has room and the generator is built; the parity LFSR
// updates through one row of GF multipliers.
// Result side: while empty is low the next parity byte and parity_last are
// on the ports; pop takes it. Bytes come highest register first; parity_last
// on the final one. If no older block waits, the first byte shows the cycle
// after the last data byte is taken, then one byte per cycle while popped.
// Two finished parity blocks can wait; when both slots are taken, full stays
// high on the input side until the receiver pops a whole block.
// The parity count is written through cfg_we/cfg_wdata; the user must write
// it only while idle, which the block does not enforce. Values below 2 or
// above MAX_EC_WORDS saturate. After reset and after each write the
// generator is rebuilt: full is high while it is set up in ST_INIT and
// built in ST_BUILD. A stalled result holds its value.
// ----------------------------------------------------------------------------
`default_nettype none

module reed_solomon_parity_encoder import rspe_pkg::*; #(
	parameter int MAX_EC_WORDS = MAX_EC_WORDS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [EC_W-1:0]  cfg_wdata,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	input  wire logic             pop,
	output logic                  empty,
	output logic [7:0]            parity_byte,
	output logic                  parity_last
);

	localparam int NW = $clog2(MAX_EC_WORDS + 1);

	q_status_t     q_stat;
	logic          enq, deq;
	logic [7:0]    enq_blk  [MAX_EC_WORDS];
	logic [7:0]    head_blk [MAX_EC_WORDS];
	logic [NW-1:0] n_eff;

	rspe_front #(.MAX_EC_WORDS(MAX_EC_WORDS), .NW(NW)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.push      (push),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.full      (full),
		.q_stat    (q_stat),
		.enq       (enq),
		.enq_blk   (enq_blk),
		.n_eff     (n_eff)
	);

	rspe_queue #(.MAX_EC_WORDS(MAX_EC_WORDS)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.enq      (enq),
		.enq_blk  (enq_blk),
		.deq      (deq),
		.head_blk (head_blk),
		.q_stat   (q_stat)
	);

	rspe_back #(.MAX_EC_WORDS(MAX_EC_WORDS), .NW(NW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_blk    (head_blk),
		.q_stat      (q_stat),
		.n_eff       (n_eff),
		.pop         (pop),
		.deq         (deq),
		.empty       (empty),
		.parity_byte (parity_byte),
		.parity_last (parity_last)
	);

endmodule

`default_nettype wire

[src/rspe_checker.sv]
// ----------------------------------------------------------------------------
// rspe_checker
// Port-level checks for the Reed-Solomon parity encoder.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_we,
	input wire logic       push,
	input wire logic       full,
	input wire logic       last_byte,
	input wire logic       pop,
	input wire logic       empty,
	input wire logic [7:0] parity_byte,
	input wire logic       parity_last
);

	// A register write starts a generator rebuild, so no request is taken next.
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> full)
		else $error("input accepted right after a configuration write");

	// A request marked last always leaves a parity block waiting.
	a_last_fills: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full && last_byte) |=> !empty)
		else $error("no parity after the last data byte");

	// Parity never appears without a last byte.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(empty && !(push && !full && last_byte)) |=> empty)
		else $error("parity appeared without a last data byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop && !cfg_we) |=>
			(!empty && $stable(parity_byte) && $stable(parity_last)))
		else $error("stalled parity byte changed");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (.*);

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Reed-Solomon parity encoder. A tracker class
// keeps its own GF(256) log tables, generator and parity LFSR, and predicts
// the parity bytes of every message. Tasks drive data requests, count writes
// and random idling on both sides, including a long receiver stall.
// ----------------------------------------------------------------------------

class rs_parity_tracker;

	int unsigned antilog [0:255];
	int unsigned logof   [0:255];
	logic [7:0]  gen     [0:rspe_pkg::MAX_EC_WORDS_DEF-1];
	logic [7:0]  lfsr    [0:rspe_pkg::MAX_EC_WORDS_DEF-1];
	int          degree;
	logic [8:0]  parity_due [$];
	int          errors;
	int          requests;
	int          messages;
	int          checked;
	int          writes;

	function new();
		int unsigned x;
		x = 1;
		for (int i = 0; i < 255; i++) begin
			antilog[i] = x;
			logof[x]   = i;
			x = x << 1;
			if (x & 32'h100) begin
				x = x ^ 32'h11D;
			end
		end
		errors   = 0;
		requests = 0;
		messages = 0;
		checked  = 0;
		writes   = 0;
		set_degree(rspe_pkg::EC_WORDS_RST);
		writes   = 0;
	endfunction

	function logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		if (a == 8'h00 || b == 8'h00) begin
			return 8'h00;
		end
		return 8'(antilog[(logof[a] + logof[b]) % 255]);
	endfunction

	// Saturate the count, rebuild the generator and drop any partial message.
	function void set_degree(input logic [rspe_pkg::EC_W-1:0] value);
		logic [7:0] root;
		degree = value;
		if (degree < 2) begin
			degree = 2;
		end
		if (degree > rspe_pkg::MAX_EC_WORDS_DEF) begin
			degree = rspe_pkg::MAX_EC_WORDS_DEF;
		end
		foreach (gen[i]) begin
			gen[i]  = 8'h00;
			lfsr[i] = 8'h00;
		end
		gen[0] = 8'h01;
		for (int i = 0; i < degree; i++) begin
			root = 8'(antilog[i]);
			for (int j = degree - 1; j > 0; j--) begin
				gen[j] = gmul(gen[j], root) ^ gen[j-1];
			end
			gen[0] = gmul(gen[0], root);
		end
		writes++;
	endfunction

	function void take_byte(input logic [7:0] data, input logic last);
		logic [7:0] fb;
		requests++;
		fb = lfsr[degree-1] ^ data;
		for (int r = degree - 1; r > 0; r--) begin
			lfsr[r] = lfsr[r-1] ^ gmul(gen[r], fb);
		end
		lfsr[0] = gmul(gen[0], fb);
		if (last) begin
			messages++;
			for (int r = 0; r < degree; r++) begin
				parity_due.push_back({r == degree - 1, lfsr[degree-1-r]});
			end
			foreach (lfsr[i]) begin
				lfsr[i] = 8'h00;
			end
		end
	endfunction

	task report(input string what);
		$display("MISMATCH: %s", what);
		errors++;
	endtask

	task match_parity(input logic [7:0] got_byte, input logic got_last);
		logic [8:0] want;
		if (parity_due.size() == 0) begin
			report($sformatf("parity byte %02h with none expected", got_byte));
			return;
		end
		want = parity_due.pop_front();
		if (got_byte !== want[7:0]) begin
			report($sformatf("parity_byte %02h, expected %02h (n=%0d)",
				got_byte, want[7:0], degree));
		end
		if (got_last !== want[8]) begin
			report($sformatf("parity_last %b, expected %b", got_last, want[8]));
		end
		checked++;
	endtask

	task close_out();
		if (parity_due.size() != 0) begin
			report($sformatf("%0d parity bytes never arrived", parity_due.size()));
		end
	endtask

endclass

module testbench;

	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 300;
	localparam int IDLE_LIMIT    = 3000;

	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      cfg_we    = 1'b0;
	logic [rspe_pkg::EC_W-1:0] cfg_wdata = '0;
	logic                      push      = 1'b0;
	logic [7:0]                data_byte = 8'h00;
	logic                      last_byte = 1'b0;
	logic                      pop       = 1'b0;
	logic                      full;
	logic                      empty;
	logic [7:0]                parity_byte;
	logic                      parity_last;

	rs_parity_tracker tracker = new();

	bit quiet     = 1'b0;
	bit long_hold = 1'b0;
	int full_stalls = 0;
	int idle_cycles = 0;

	reed_solomon_parity_encoder dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.push        (push),
		.full        (full),
		.data_byte   (data_byte),
		.last_byte   (last_byte),
		.pop         (pop),
		.empty       (empty),
		.parity_byte (parity_byte),
		.parity_last (parity_last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Everything is sampled at the edge, before the block's own updates land.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_we) begin
				tracker.set_degree(cfg_wdata);
			end
			if (push && !full) begin
				tracker.take_byte(data_byte, last_byte);
			end
			if (push && full) begin
				full_stalls++;
			end
			if (pop && !empty) begin
				tracker.match_parity(parity_byte, parity_last);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || cfg_we) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
				$display("testbench: done, errors");
				$finish;
			end
		end
	end

	// Receiver: random stalls, plus one long hold-off when asked for.
	initial begin
		@(posedge clk);
		while (!arst_n) begin
			@(posedge clk);
		end
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				pop <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
		end
	end

	// Called at a clock edge; returns at the edge where the request is taken.
	task send_byte(input logic [7:0] data, input logic last);
		push      <= 1'b1;
		data_byte <= data;
		last_byte <= last;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
	endtask

	task sender_gap();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	task send_message(input int len, input bit ends);
		for (int i = 0; i < len; i++) begin
			sender_gap();
			send_byte(8'($urandom_range(0, 255)), ends && (i == len - 1));
		end
	endtask

	// Drain every expected parity byte, then give a partial message time to settle.
	task settle();
		push <= 1'b0;
		@(posedge clk);
		while (tracker.parity_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_count(input logic [rspe_pkg::EC_W-1:0] value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task random_phase(input logic [rspe_pkg::EC_W-1:0] value, input int budget);
		int sent;
		int len;
		write_count(value);
		sent = 0;
		while (sent < budget) begin
			len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			send_message(len, 1'b1);
			sent += len;
		end
		// Now and then leave a message open so the next write discards it.
		if ($urandom_range(0, 3) == 0) begin
			send_message($urandom_range(1, 3), 1'b0);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset count of ten: extreme bytes, a one-byte message, an all-zero one.
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b1);

		// Counts below the range saturate to two.
		write_count(6'd0);
		send_byte(8'hAA, 1'b0);
		send_byte(8'h55, 1'b1);

		// Counts above the range saturate to the maximum.
		write_count(6'd63);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hFE, 1'b1);

		// A write in the middle of a message throws the message away.
		write_count(6'd1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		write_count(6'd32);
		send_byte(8'h9C, 1'b1);

		write_count(6'd33);
		send_byte(8'h01, 1'b0);
		send_byte(8'h80, 1'b1);

		write_count(6'd2);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);

		random_phase(6'd32, 22);
		random_phase(6'($urandom_range(0, 63)), 22);

		// Receiver holds off while short messages keep coming, so the block queue fills.
		write_count(6'd32);
		long_hold = 1'b1;
		for (int m = 0; m < 6; m++) begin
			send_message($urandom_range(1, 3), 1'b1);
		end

		random_phase(6'd2, 22);
		random_phase(6'($urandom_range(0, 63)), 22);

		quiet = 1'b1;
		random_phase(6'($urandom_range(0, 63)), 25);

		settle();
		tracker.close_out();
		$display("covered %0d data requests in %0d messages, %0d parity bytes checked",
			tracker.requests, tracker.messages, tracker.checked);
		$display("count writes: %0d, cycles with input held off by full: %0d",
			tracker.writes, full_stalls);
		if (tracker.errors == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

[reed_solomon_parity_encoder.f]
src/rspe_pkg.sv
src/rspe_front.sv
src/rspe_queue.sv
src/rspe_back.sv
src/reed_solomon_parity_encoder.sv
src/rspe_checker.sv
tb/sv/testbench.sv
